@@ design/smx_pkg.sv @@
// Package: opcodes, error codes, sizes and sequencer states for the stack machine core.
package smx_pkg;
    localparam int STACK_DEPTH = 256;
    localparam int SP_W = $clog2(STACK_DEPTH) + 1;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int PC_W = 17;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_POP = 5'd1, OP_PUSHR = 5'd2, OP_POPR = 5'd3,
        OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
        OP_OUT = 5'd8, OP_IN = 5'd9, OP_JMP = 5'd10, OP_JEQ = 5'd11,
        OP_JNE = 5'd12, OP_JA = 5'd13, OP_JAE = 5'd14, OP_JB = 5'd15,
        OP_JBE = 5'd16, OP_RET = 5'd17
    } t_op;

    typedef enum logic [2:0] {
        ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
        ERR_DIVZ = 3'd3, ERR_JUMP = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RDA, ST_RDB, ST_EXEC, ST_ALU, ST_DONE, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        ALU_MUL, ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    localparam logic [2:0] REG_PC = 3'd4;
    localparam logic [1:0] PADDR_PROGLEN = 2'd0;
endpackage

@@ design/smx_alu.sv @@
// Shared iterative unit: shift-add multiply and restoring signed divide, one bit per cycle.
module smx_alu
    import smx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_ctl    i_ctl,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_result
);
    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    t_alu_op     r_op, n_op;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic        r_neg, n_neg;
    logic [64:0] w_trial;
    logic [63:0] w_rem;

    assign w_rem   = {r_acc[62:0], r_x[63]};
    assign w_trial = {1'b0, w_rem} - {1'b0, r_y};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_neg  = r_neg;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
            n_op   = i_ctl.op;
            n_acc  = '0;
            if (i_ctl.op == ALU_MUL) begin
                n_x   = i_a;
                n_y   = i_b;
                n_neg = 1'b0;
            end else begin
                n_x   = i_a[63] ? (64'd0 - i_a) : i_a;
                n_y   = i_b[63] ? (64'd0 - i_b) : i_b;
                n_neg = i_a[63] ^ i_b[63];
            end
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 7'd1;
                if (r_op == ALU_MUL) begin
                    if (r_x[0]) begin
                        n_acc = r_acc + r_y;
                    end
                    n_x = r_x >> 1;
                    n_y = r_y << 1;
                end else begin
                    if (!w_trial[64]) begin
                        n_acc = w_trial[63:0];
                        n_x   = {r_x[62:0], 1'b1};
                    end else begin
                        n_acc = w_rem;
                        n_x   = {r_x[62:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_neg <= n_neg;
    end

    assign o_done   = r_busy && (r_cnt == 7'd64);
    assign o_result = (r_op == ALU_MUL) ? r_acc : (r_neg ? (64'd0 - r_x) : r_x);
endmodule

@@ design/stack_machine_execute_core.sv @@
// Top level: stack machine instruction executor with operand stack, registers and sequencer.
// One instruction per input transaction, one result transaction per instruction. Most
// instructions go from acceptance through RDA and RDB (two stack RAM reads), EXEC
// (execute) and OUT (result), then back to IDLE, where the next one is accepted.
// Mul and div go from EXEC through ALU, which waits on the shared one-bit-per-cycle
// multiply/divide unit, and DONE (write-back) to OUT. A new instruction is taken only once the
// previous result has been accepted. The operand stack is a 256-entry RAM with one read
// and one write port.
module stack_machine_execute_core
    import smx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_operation,
    input  logic [63:0] i_operand,
    input  logic [2:0]  i_reg_index,
    input  logic [63:0] i_in_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_next_pc,
    output logic [63:0] o_out_value,
    output logic        o_out_valid,
    output logic        o_done_res,
    output logic [2:0]  o_error_code
);
    t_state r_state, n_state;
    logic [63:0] r_mem [STACK_DEPTH];
    logic [63:0] r_rdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    logic        w_we;
    logic [63:0] w_wdata;

    logic [15:0] r_plen;
    logic [SP_W-1:0] r_sp;
    logic [PC_W-1:0] r_pc;
    logic [63:0] r_rf [5];

    logic [4:0]  r_op;
    logic [63:0] r_imm, r_inv, r_a, r_b;
    logic [2:0]  r_ri;

    logic [PC_W-1:0] r_npc;
    logic [63:0] r_outv;
    logic        r_outvld;
    logic [2:0]  r_err;

    t_alu_ctl    w_alu;
    logic        w_alu_done;
    logic [63:0] w_alu_res;

    // execute-cycle decode
    logic [2:0]  w_err;
    logic        w_jump, w_push, w_pop, w_isout, w_isalu;
    logic [63:0] w_target, w_pushv;
    logic        w_gt_ab, w_gt_ba;
    logic [PC_W-1:0] w_seq;

    assign pready = 1'b1;
    assign prdata = (paddr == PADDR_PROGLEN) ? {16'd0, r_plen} : 32'd0;

    assign w_gt_ab = (r_a ^ 64'h8000_0000_0000_0000) > (r_b ^ 64'h8000_0000_0000_0000);
    assign w_gt_ba = (r_b ^ 64'h8000_0000_0000_0000) > (r_a ^ 64'h8000_0000_0000_0000);
    assign w_seq = r_pc + 17'd1;

    always_comb begin
        w_err = ERR_OK;
        w_jump = 1'b0;
        w_push = 1'b0;
        w_pop = 1'b0;
        w_isout = 1'b0;
        w_isalu = 1'b0;
        w_target = r_imm;
        w_pushv = r_imm;
        case (r_op)
            OP_PUSH, OP_PUSHR, OP_IN: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    w_err = ERR_OVER;
                end else begin
                    w_push = 1'b1;
                end
                if (r_op == OP_IN) begin
                    w_pushv = r_inv;
                end else if (r_op == OP_PUSHR) begin
                    w_pushv = (r_ri < 3'd5) ? r_rf[r_ri] : 64'd0;
                end
            end
            OP_POP, OP_POPR, OP_OUT: begin
                if (r_sp == '0) begin
                    w_err = ERR_UNDER;
                end else begin
                    w_pop = 1'b1;
                    w_isout = (r_op == OP_OUT);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (r_sp < SP_W'(2)) begin
                    w_err = ERR_UNDER;
                end else if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    w_err = ERR_OVER;
                end else if (r_op == OP_DIV && r_b == 64'd0) begin
                    w_err = ERR_DIVZ;
                end else begin
                    w_push = 1'b1;
                    w_isalu = (r_op == OP_MUL) || (r_op == OP_DIV);
                end
                w_pushv = (r_op == OP_ADD) ? (r_a + r_b) : (r_a - r_b);
            end
            OP_JMP: begin
                w_jump = 1'b1;
            end
            OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
                if (r_sp < SP_W'(2)) begin
                    w_err = ERR_UNDER;
                end else begin
                    case (r_op)
                        OP_JEQ:  w_jump = (r_a == r_b);
                        OP_JNE:  w_jump = (r_a != r_b);
                        OP_JA:   w_jump = w_gt_ab;
                        OP_JAE:  w_jump = !w_gt_ba;
                        OP_JB:   w_jump = w_gt_ba;
                        default: w_jump = !w_gt_ab;
                    endcase
                end
            end
            OP_RET: begin
                if (r_sp == '0) begin
                    w_err = ERR_UNDER;
                end else begin
                    w_jump = 1'b1;
                    w_pop = 1'b1;
                    w_target = r_a + 64'd1;
                end
            end
            default: ;
        endcase
        if (w_err == ERR_OK && w_jump && w_target > {48'd0, r_plen}) begin
            w_err = ERR_JUMP;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_RDA;
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_EXEC;
            ST_EXEC: n_state = (w_err == ERR_OK && w_isalu) ? ST_ALU : ST_OUT;
            ST_ALU:  if (w_alu_done) n_state = ST_DONE;
            ST_DONE: n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
        w_alu.start = (r_state == ST_EXEC) && (w_err == ERR_OK) && w_isalu;
        w_alu.op = (r_op == OP_MUL) ? ALU_MUL : ALU_DIV;
        w_raddr = ADDR_W'(r_sp - SP_W'(1));
        if (r_state == ST_RDA) begin
            w_raddr = ADDR_W'(r_sp - SP_W'(2));
        end
        w_we = 1'b0;
        w_wdata = w_pushv;
        w_waddr = r_sp[ADDR_W-1:0];
        if (r_state == ST_EXEC && w_err == ERR_OK && w_push && !w_isalu) begin
            w_we = 1'b1;
        end else if (r_state == ST_DONE) begin
            // stack pointer already advanced in the execute cycle
            w_we = 1'b1;
            w_wdata = w_alu_res;
            w_waddr = ADDR_W'(r_sp - SP_W'(1));
        end
    end

    smx_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_alu),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    // stack RAM: top entry read in IDLE, second in RDA; writes in EXEC/DONE
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_plen <= '0;
            r_sp <= '0;
            r_pc <= '0;
            for (int k = 0; k < 5; k++) begin
                r_rf[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == PADDR_PROGLEN) begin
                r_plen <= pwdata[15:0];
            end
            if (r_state == ST_EXEC && w_err == ERR_OK) begin
                r_pc <= w_jump ? w_target[PC_W-1:0] : w_seq;
                if (w_push) begin
                    r_sp <= r_sp + SP_W'(1);
                end else if (w_pop) begin
                    r_sp <= r_sp - SP_W'(1);
                end
                if (r_op == OP_POPR && r_ri < 3'd5) begin
                    r_rf[r_ri] <= r_a;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op  <= i_operation;
            r_imm <= i_operand;
            r_ri  <= i_reg_index;
            r_inv <= i_in_value;
            r_a   <= '0;
            r_b   <= '0;
        end
        if (r_state == ST_RDA && r_sp >= SP_W'(1)) begin
            r_a <= r_rdata;
        end
        if (r_state == ST_RDB && r_sp >= SP_W'(2)) begin
            r_b <= r_rdata;
        end
        if (r_state == ST_EXEC) begin
            r_err <= w_err;
            r_outvld <= (w_err == ERR_OK) && w_isout;
            r_outv <= ((w_err == ERR_OK) && w_isout) ? r_a : 64'd0;
            if (w_err != ERR_OK) begin
                r_npc <= r_pc;
            end else begin
                r_npc <= w_jump ? w_target[PC_W-1:0] : w_seq;
            end
        end
    end

    assign o_next_pc = r_npc;
    assign o_out_value = r_outv;
    assign o_out_valid = r_outvld;
    assign o_done_res = (r_npc >= {1'b0, r_plen});
    assign o_error_code = r_err;
endmodule
